// ===== hw/rtl/address_region_table_macros.svh =====
// ----------------------------------------------------------------------------
// address region table assertion macros
// shared property shorthands for the block's checkers
// ----------------------------------------------------------------------------
`ifndef ADDRESS_REGION_TABLE_MACROS_SVH
`define ADDRESS_REGION_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define ART_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ART_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/art_pkg.sv =====
// ----------------------------------------------------------------------------
// art_pkg
// types, codes and defaults shared by the address region table
// ----------------------------------------------------------------------------
package art_pkg;

    // default table depth
    localparam int unsigned MAX_REGIONS_DEF = 16;

    // field widths
    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned RCNT_W   = 5;

    // request codes
    localparam logic [KIND_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] REQ_LOOKUP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // request transaction
    typedef struct packed {
        logic [KIND_W-1:0] req_type;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] region_size;
    } t_art_req;

    // response transaction
    typedef struct packed {
        logic                in_region;
        logic [STATUS_W-1:0] status;
        logic [RCNT_W-1:0]   region_count;
    } t_art_rsp;

    // token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              found;
        logic [ADDR_W-1:0] last_start;
        logic [ADDR_W-1:0] last_end;
    } t_art_tok;

    // entry write broadcast to all cells
    typedef struct packed {
        logic              add_en;
        logic              move_en;
        logic [ADDR_W-1:0] region_start;
        logic [ADDR_W-1:0] region_end;
    } t_art_wr;

endpackage

// ===== hw/rtl/art_cell.sv =====
// ----------------------------------------------------------------------------
// art_cell
// one table entry; checks the passing token against its region and hands
// the token on to the next cell
// ----------------------------------------------------------------------------
module art_cell import art_pkg::*; #(
    parameter int unsigned CELL_IDX = 0,
    parameter int unsigned CNT_W    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [KIND_W-1:0]    i_req_type,
    input  logic [ADDR_W-1:0]    i_address,
    input  t_art_wr              i_wr,
    input  t_art_tok             i_tok,
    output t_art_tok             o_tok
);

    logic [ADDR_W-1:0] r_start;
    logic [ADDR_W-1:0] r_end;
    logic              r_match;
    t_art_tok          r_tok;
    t_art_tok          n_tok;
    logic              w_live;
    logic              w_is_last;
    logic              w_first_match;

    // entry occupancy and position
    assign w_live    = CNT_W'(CELL_IDX) < i_count;
    assign w_is_last = CNT_W'(CELL_IDX + 1) == i_count;

    // first entry whose start equals the removed start
    assign w_first_match = w_live && (i_req_type == REQ_REMOVE) && !i_tok.found
                           && (r_start == i_address);

    // token update
    always_comb begin
        n_tok = i_tok;
        if (w_live && (r_start <= i_address) && (i_address < r_end)) begin
            n_tok.hit = 1'b1;
        end
        if (w_first_match) begin
            n_tok.found = 1'b1;
        end
        if (w_is_last) begin
            n_tok.last_start = r_start;
            n_tok.last_end   = r_end;
        end
    end

    // token register toward the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // remember whether this cell is the slot to refill
    always_ff @(posedge i_clk) begin
        if (i_tok.valid) begin
            r_match <= w_first_match;
        end
    end

    // entry write on append or on move of the last entry
    always_ff @(posedge i_clk) begin
        if ((i_wr.add_en && (CNT_W'(CELL_IDX) == i_count)) || (i_wr.move_en && r_match)) begin
            r_start <= i_wr.region_start;
            r_end   <= i_wr.region_end;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/address_region_table.sv =====
// flow: the request is registered, its token walks the cell chain one cell per cycle,
//   waits in the finish register and is then registered at the output; one request
//   is in flight at a time, and a new one is taken once the last result is committed
// reset: synchronous active low; clears the entry count and all handshake
//   state, entry contents are left as they are and are never read before written
// ----------------------------------------------------------------------------
// address_region_table
// table of address regions with add, remove by start and lookup requests
// ----------------------------------------------------------------------------
module address_region_table import art_pkg::*; #(
    parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_art_req i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_art_rsp o_out_data
);

    localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);

    logic             r_busy;
    logic             r_go;
    t_art_req         r_req;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_fin_valid;
    t_art_tok         r_fin;
    logic             r_out_valid;
    t_art_rsp         r_out;
    t_art_rsp         n_out;
    t_art_wr          w_wr;
    t_art_tok         w_tok [MAX_REGIONS+1];
    logic             w_accept;
    logic             w_commit;
    logic             w_full;

    assign w_accept = i_in_valid && !r_busy;
    assign w_commit = r_fin_valid && (!r_out_valid || i_out_ready);
    assign w_full   = r_count == CNT_W'(MAX_REGIONS);

    // request capture and busy tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_go   <= 1'b0;
        end else begin
            r_go <= w_accept;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
    end

    // token launch into the first cell
    always_comb begin
        w_tok[0]            = '0;
        w_tok[0].valid      = r_go;
    end

    // cell chain
    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        art_cell #(
            .CELL_IDX (g),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_count    (r_count),
            .i_req_type (r_req.req_type),
            .i_address  (r_req.address),
            .i_wr       (w_wr),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    // finished token waits here for the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_tok[MAX_REGIONS].valid) begin
            r_fin_valid <= 1'b1;
        end else if (w_commit) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok[MAX_REGIONS].valid) begin
            r_fin <= w_tok[MAX_REGIONS];
        end
    end

    // table update, count and response
    always_comb begin
        w_wr.add_en   = w_commit && (r_req.req_type == REQ_ADD) && !w_full;
        w_wr.move_en  = w_commit && (r_req.req_type == REQ_REMOVE) && r_fin.found;
        if (r_req.req_type == REQ_ADD) begin
            w_wr.region_start = r_req.address;
            w_wr.region_end   = r_req.address + r_req.region_size;
        end else begin
            w_wr.region_start = r_fin.last_start;
            w_wr.region_end   = r_fin.last_end;
        end

        n_count = r_count;
        if (w_wr.add_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_wr.move_en) begin
            n_count = r_count - CNT_W'(1);
        end

        n_out.in_region    = (r_req.req_type == REQ_LOOKUP) && r_fin.hit;
        n_out.status       = ST_DONE;
        n_out.region_count = RCNT_W'(n_count);
        if ((r_req.req_type == REQ_ADD) && w_full) begin
            n_out.status = ST_FULL;
        end else if ((r_req.req_type == REQ_REMOVE) && !r_fin.found) begin
            n_out.status = ST_NOT_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_commit) begin
            r_count <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/art_checker.sv =====
// ----------------------------------------------------------------------------
// art_checker
// port-level checks for the address region table
// ----------------------------------------------------------------------------
`include "address_region_table_macros.svh"

module art_checker import art_pkg::*; #(
    parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF
) (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_art_req i_in_data,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_art_rsp o_out_data
);

    // a stalled response holds
    `ART_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "response dropped or changed while stalled")

    // one request in flight at a time
    `ART_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "request taken while another is in flight")

    // a hit is only reported on a completed request
    `ART_ASSERT_IMP(a_hit_done, i_clk, i_rst_n, o_out_valid && o_out_data.in_region, o_out_data.status == ST_DONE, "hit reported with error status")

    // a full table reports the full count
    `ART_ASSERT_IMP(a_full_count, i_clk, i_rst_n, o_out_valid && (o_out_data.status == ST_FULL), o_out_data.region_count == RCNT_W'(MAX_REGIONS), "full status with wrong count")

endmodule

bind address_region_table art_checker #(
    .MAX_REGIONS (MAX_REGIONS)
) u_art_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/tb_address_region_table.sv =====
// ----------------------------------------------------------------------------
// tb_address_region_table
// drives add, remove and lookup requests through the region table with random
// idle and stall on both channels; each result is checked against a behavioral
// copy of the table that is updated as every request transaction is accepted
// ----------------------------------------------------------------------------
module tb_address_region_table;
    import art_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = MAX_REGIONS_DEF;

    // request code with no operation behind it
    localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;

    localparam int unsigned RANDOM_ITEMS = 620;
    localparam int unsigned GAP_MAX      = 13;
    localparam int unsigned PRESSURE_AT  = 120;
    localparam int unsigned PRESSURE_LEN = 300;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned TAIL_CYCLES  = 3 * (DEPTH + 3);

    localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};
    localparam logic [ADDR_W-1:0] HEAP_BASE = 64'h0000_7F00_0000_0000;

    // request waiting for the driver, with the idle that follows it
    typedef struct {
        t_art_req    req;
        int unsigned gap;
    } t_req_slot;

    // region as the stimulus side remembers it
    typedef struct {
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
    } t_span;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     in_valid    = 1'b0;
    logic     o_in_ready;
    t_art_req in_data     = '0;
    logic     o_out_valid;
    logic     out_ready   = 1'b0;
    t_art_rsp o_out_data;

    t_req_slot   req_queue[$];
    t_req_slot   head_slot;
    t_art_rsp    rsp_expected[$];
    t_span       known[$];

    // behavioral copy of the table
    logic [ADDR_W-1:0] tbl_start [DEPTH];
    logic [ADDR_W-1:0] tbl_end   [DEPTH];
    int unsigned       tbl_count = 0;

    int unsigned err_count  = 0;
    int unsigned gap_left   = 0;
    int unsigned rx_count   = 0;
    int unsigned wait_left  = 0;
    int unsigned hold_left  = 0;
    int unsigned idle_count = 0;
    int unsigned rx_wait;

    address_region_table #(
        .MAX_REGIONS (DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one request to the table copy and return the result it gives
    function automatic t_art_rsp table_apply(t_art_req req);
        t_art_rsp rsp;
        bit       matched;
        rsp = '0;
        rsp.status = ST_DONE;
        matched = 1'b0;
        case (req.req_type)
            REQ_ADD: begin
                if (tbl_count < DEPTH) begin
                    tbl_start[tbl_count] = req.address;
                    tbl_end[tbl_count]   = req.address + req.region_size;
                    tbl_count++;
                end else begin
                    rsp.status = ST_FULL;
                end
            end
            REQ_REMOVE: begin
                rsp.status = ST_NOT_FOUND;
                // lowest-indexed match is replaced by the last entry
                for (int i = 0; i < tbl_count && !matched; i++) begin
                    if (tbl_start[i] == req.address) begin
                        tbl_start[i] = tbl_start[tbl_count - 1];
                        tbl_end[i]   = tbl_end[tbl_count - 1];
                        tbl_count--;
                        matched = 1'b1;
                        rsp.status = ST_DONE;
                    end
                end
            end
            REQ_LOOKUP: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (req.address >= tbl_start[i] && req.address < tbl_end[i])
                        rsp.in_region = 1'b1;
                end
            end
            default: ;
        endcase
        rsp.region_count = RCNT_W'(tbl_count);
        return rsp;
    endfunction

    // address mix: clustered heap, full range, both ends of the space
    function automatic logic [ADDR_W-1:0] pick_addr();
        case ($urandom_range(0, 5))
            0, 1:    return HEAP_BASE + $urandom_range(0, 32'h3FFF);
            2:       return {$urandom, $urandom};
            3:       return ALL_ONES - $urandom_range(0, 255);
            4:       return ADDR_W'($urandom_range(0, 255));
            default: return {32'h0, $urandom};
        endcase
    endfunction

    // size mix: empty, small, huge and wrapping
    function automatic logic [ADDR_W-1:0] pick_size();
        case ($urandom_range(0, 5))
            0:       return '0;
            1, 2:    return ADDR_W'($urandom_range(1, 4096));
            3:       return {$urandom, $urandom};
            4:       return ALL_ONES - $urandom_range(0, 255);
            default: return ADDR_W'($urandom);
        endcase
    endfunction

    task automatic push_req(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                            logic [ADDR_W-1:0] size, int unsigned gap);
        t_req_slot slot;
        slot.req.req_type    = kind;
        slot.req.address     = addr;
        slot.req.region_size = size;
        slot.gap             = gap;
        req_queue.push_back(slot);
    endtask

    // stimulus
    initial begin
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] size;
        int unsigned       r;
        int unsigned       gap;
        int unsigned       idx;
        bit                heavy_add;
        t_span             s;

        // directed: empty table, wrapped and empty regions, duplicate starts
        push_req(REQ_LOOKUP, '0, '0, $urandom_range(0, GAP_MAX));
        push_req(REQ_REMOVE, 64'h1000, ALL_ONES, $urandom_range(0, GAP_MAX));
        push_req(REQ_ADD, 64'h1000, 64'h100, $urandom_range(0, GAP_MAX));
        push_req(REQ_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, $urandom_range(0, GAP_MAX));
        push_req(REQ_ADD, 64'h5000, '0, $urandom_range(0, GAP_MAX));
        push_req(REQ_ADD, 64'h1000, 64'h10, $urandom_range(0, GAP_MAX));
        push_req(REQ_LOOKUP, 64'h1000, '0, $urandom_range(0, GAP_MAX));
        push_req(REQ_LOOKUP, 64'h10FF, '0, $urandom_range(0, GAP_MAX));
        push_req(REQ_LOOKUP, 64'h1100, '0, $urandom_range(0, GAP_MAX));
        push_req(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFF8, '0, $urandom_range(0, GAP_MAX));
        push_req(REQ_LOOKUP, 64'h5000, '0, $urandom_range(0, GAP_MAX));
        push_req(REQ_UNUSED, ALL_ONES, ALL_ONES, $urandom_range(0, GAP_MAX));
        push_req(REQ_REMOVE, 64'h1000, '0, $urandom_range(0, GAP_MAX));
        push_req(REQ_LOOKUP, 64'h1050, '0, $urandom_range(0, GAP_MAX));
        push_req(REQ_LOOKUP, 64'h100F, '0, $urandom_range(0, GAP_MAX));
        push_req(REQ_REMOVE, 64'h7777, '0, $urandom_range(0, GAP_MAX));
        push_req(REQ_ADD, '0, ALL_ONES, $urandom_range(0, GAP_MAX));
        push_req(REQ_LOOKUP, ALL_ONES, '0, $urandom_range(0, GAP_MAX));
        push_req(REQ_LOOKUP, ALL_ONES - 1, '0, $urandom_range(0, GAP_MAX));
        // fill the table, then two adds past full
        for (int k = 4; k <= DEPTH; k++)
            push_req(REQ_ADD, 64'h9000 + k * 64'h100, 64'h80, 0);
        push_req(REQ_ADD, ALL_ONES, ALL_ONES, $urandom_range(0, GAP_MAX));

        // random: add-heavy and remove-heavy stretches alternate
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            heavy_add = ((i / 70) % 2 == 0);
            r = $urandom_range(0, 99);
            if (r < 2)
                kind = REQ_UNUSED;
            else if (r < (heavy_add ? 55 : 20))
                kind = REQ_ADD;
            else if (r < (heavy_add ? 70 : 60))
                kind = REQ_REMOVE;
            else
                kind = REQ_LOOKUP;
            size = pick_size();
            addr = pick_addr();
            case (kind)
                REQ_ADD: begin
                    // sometimes reuse a start to get duplicates
                    if (known.size() != 0 && $urandom_range(0, 9) == 0)
                        addr = known[$urandom_range(0, known.size() - 1)].lo;
                    if (known.size() < DEPTH) begin
                        s.lo = addr;
                        s.hi = addr + size;
                        known.push_back(s);
                    end
                end
                REQ_REMOVE: begin
                    if (known.size() != 0 && $urandom_range(0, 3) != 0) begin
                        idx = $urandom_range(0, known.size() - 1);
                        addr = known[idx].lo;
                        known.delete(idx);
                    end
                end
                REQ_LOOKUP: begin
                    // probe the edges of a known region
                    if (known.size() != 0 && $urandom_range(0, 3) != 0) begin
                        s = known[$urandom_range(0, known.size() - 1)];
                        case ($urandom_range(0, 4))
                            0:       addr = s.lo;
                            1:       addr = s.lo - 1;
                            2:       addr = s.hi - 1;
                            3:       addr = s.hi;
                            default: addr = s.lo + $urandom_range(0, 4096);
                        endcase
                    end
                end
                default: ;
            endcase
            gap = (i % 50 < 10) ? 0 : $urandom_range(0, GAP_MAX);
            push_req(kind, addr, size, gap);
        end

        // reset
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain, then let any stray result show up
        while (req_queue.size() != 0 || in_valid || rsp_expected.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("[address_region_table] OK");
        else
            $display("[address_region_table] ERROR");
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left <= 0;
        end else if (!in_valid || o_in_ready) begin
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (req_queue.size() != 0) begin
                head_slot = req_queue.pop_front();
                in_valid <= 1'b1;
                in_data  <= head_slot.req;
                gap_left <= head_slot.gap;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver: per-result wait counted while valid is up, one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            wait_left <= 0;
            hold_left <= 0;
            rx_count  <= 0;
        end else if (out_ready && o_out_valid) begin
            rx_count <= rx_count + 1;
            rx_wait = ((rx_count / 50) % 3 == 0) ? 0 : $urandom_range(0, GAP_MAX);
            if (rx_count == PRESSURE_AT) begin
                out_ready <= 1'b0;
                hold_left <= PRESSURE_LEN;
                wait_left <= 0;
            end else if (rx_wait == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                wait_left <= rx_wait;
            end
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!out_ready) begin
            if (wait_left == 0)
                out_ready <= 1'b1;
            else if (o_out_valid)
                wait_left <= wait_left - 1;
        end
    end

    // monitor: check the result transaction first, then predict the new request
    always @(posedge i_clk) begin
        t_art_rsp exp_rsp;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                if (rsp_expected.size() == 0) begin
                    err_count++;
                    $display("%0t unexpected result: in_region %0d status %0d count %0d",
                             $time, o_out_data.in_region, o_out_data.status,
                             o_out_data.region_count);
                end else begin
                    exp_rsp = rsp_expected.pop_front();
                    if (o_out_data.in_region !== exp_rsp.in_region) begin
                        err_count++;
                        $display("%0t in_region mismatch: expected %0d, actual %0d",
                                 $time, exp_rsp.in_region, o_out_data.in_region);
                    end
                    if (o_out_data.status !== exp_rsp.status) begin
                        err_count++;
                        $display("%0t status mismatch: expected %0d, actual %0d",
                                 $time, exp_rsp.status, o_out_data.status);
                    end
                    if (o_out_data.region_count !== exp_rsp.region_count) begin
                        err_count++;
                        $display("%0t region_count mismatch: expected %0d, actual %0d",
                                 $time, exp_rsp.region_count, o_out_data.region_count);
                    end
                end
            end
            if (in_valid && o_in_ready)
                rsp_expected.push_back(table_apply(in_data));
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT) begin
                $display("%0t timeout: no transaction for %0d cycles", $time, idle_count);
                $display("[address_region_table] ERROR");
                $finish;
            end
        end
    end

endmodule
